// ----- src/sctad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctad_pkg: shared types, codes and key tables of the scancode decoder
// Holds the set 1 scancode constants and the normal and shifted key maps.
// ----------------------------------------------------------------------------
package sctad_pkg;

	localparam logic [7:0] PrefixCode = 8'hE0;
	localparam int unsigned BreakBit = 7;
	localparam logic [6:0] LShiftKey = 7'h2A;
	localparam logic [6:0] RShiftKey = 7'h36;

	// Decode result handed from the decoder to the output register.
	typedef struct packed {
		logic       emit;
		logic [6:0] ch;
	} dec_res_t;

	// Normal (unshifted) key map; zero means the key has no character.
	function automatic logic [6:0] plain_char(input logic [6:0] key);
		logic [6:0] ch;
		case (key)
			7'h02: ch = 7'h31;
			7'h03: ch = 7'h32;
			7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;
			7'h06: ch = 7'h35;
			7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;
			7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;
			7'h0C: ch = 7'h2D;
			7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08;
			7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71;
			7'h11: ch = 7'h77;
			7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;
			7'h14: ch = 7'h74;
			7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;
			7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;
			7'h1A: ch = 7'h5B;
			7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h61;
			7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;
			7'h22: ch = 7'h67;
			7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;
			7'h25: ch = 7'h6B;
			7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;
			7'h28: ch = 7'h27;
			7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;
			7'h2C: ch = 7'h7A;
			7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;
			7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;
			7'h32: ch = 7'h6D;
			7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;
			7'h35: ch = 7'h2F;
			7'h39: ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Shifted key map; zero means the key has no character.
	function automatic logic [6:0] shift_char(input logic [6:0] key);
		logic [6:0] ch;
		case (key)
			7'h02: ch = 7'h21;
			7'h03: ch = 7'h40;
			7'h04: ch = 7'h23;
			7'h05: ch = 7'h24;
			7'h06: ch = 7'h25;
			7'h07: ch = 7'h5E;
			7'h08: ch = 7'h26;
			7'h09: ch = 7'h2A;
			7'h0A: ch = 7'h28;
			7'h0B: ch = 7'h29;
			7'h0C: ch = 7'h5F;
			7'h0D: ch = 7'h2B;
			7'h0E: ch = 7'h08;
			7'h0F: ch = 7'h09;
			7'h10: ch = 7'h51;
			7'h11: ch = 7'h57;
			7'h12: ch = 7'h45;
			7'h13: ch = 7'h52;
			7'h14: ch = 7'h54;
			7'h15: ch = 7'h59;
			7'h16: ch = 7'h55;
			7'h17: ch = 7'h49;
			7'h18: ch = 7'h4F;
			7'h19: ch = 7'h50;
			7'h1A: ch = 7'h7B;
			7'h1B: ch = 7'h7D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h41;
			7'h1F: ch = 7'h53;
			7'h20: ch = 7'h44;
			7'h21: ch = 7'h46;
			7'h22: ch = 7'h47;
			7'h23: ch = 7'h48;
			7'h24: ch = 7'h4A;
			7'h25: ch = 7'h4B;
			7'h26: ch = 7'h4C;
			7'h27: ch = 7'h3A;
			7'h28: ch = 7'h22;
			7'h29: ch = 7'h7E;
			7'h2B: ch = 7'h7C;
			7'h2C: ch = 7'h5A;
			7'h2D: ch = 7'h58;
			7'h2E: ch = 7'h43;
			7'h2F: ch = 7'h56;
			7'h30: ch = 7'h42;
			7'h31: ch = 7'h4E;
			7'h32: ch = 7'h4D;
			7'h33: ch = 7'h3C;
			7'h34: ch = 7'h3E;
			7'h35: ch = 7'h3F;
			7'h39: ch = 7'h20;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- src/sctad_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctad_decode: keyboard state and character lookup
// Keeps the prefix and shift flags and maps one registered byte to a result.
// ----------------------------------------------------------------------------
module sctad_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          code,
	input  logic                fire,
	output sctad_pkg::dec_res_t res
);

	logic       prefix_q;
	logic       lshift_q;
	logic       rshift_q;
	logic       is_prefix;
	logic       is_break;
	logic [6:0] key;
	logic [6:0] ch;

	assign is_prefix = (code == sctad_pkg::PrefixCode);
	assign is_break  = code[sctad_pkg::BreakBit];
	assign key       = code[6:0];
	assign ch        = (lshift_q || rshift_q) ? sctad_pkg::shift_char(key)
	                                          : sctad_pkg::plain_char(key);

	// Only an unprefixed make code of a non-shift key can produce a character.
	assign res.emit = !is_prefix && !prefix_q && !is_break &&
	                  (key != sctad_pkg::LShiftKey) && (key != sctad_pkg::RShiftKey) &&
	                  (ch != 7'h00);
	assign res.ch   = ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
		end else if (fire) begin
			if (is_prefix) begin
				prefix_q <= 1'b1;
			end else if (prefix_q) begin
				prefix_q <= 1'b0;
			end else if (key == sctad_pkg::LShiftKey) begin
				lshift_q <= !is_break;
			end else if (key == sctad_pkg::RShiftKey) begin
				rshift_q <= !is_break;
			end
		end
	end

endmodule

// ----- src/scancode_to_ascii_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_unit: set 1 keyboard scancode to ASCII decoder
// Path: input register, decoder, output register. Throughput: one word per
// cycle via the single input register unless the output register stalls.
// Reset (arst_n low, asynchronous): prefix and shift flags clear, both
// register stages empty; the character payload register is not reset.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] ascii_char
);

	// Stage 1 holds the accepted scancode word. The decoder looks at it
	// together with the current flags; the flags move on when the word
	// leaves stage 1, so words are decoded strictly in arrival order.
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                fire;
	logic                out_free;
	logic                char_valid_q;
	logic [6:0]          char_q;
	sctad_pkg::dec_res_t res;

	// The output register can take a new word when it is empty or being
	// drained this cycle. Words that produce no character never need it.
	assign out_free   = !char_valid_q || !char_stall;
	assign fire       = valid_s1 && (!res.emit || out_free);
	assign scan_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && !scan_stall) begin
			byte_s1 <= scan_byte;
		end
	end

	sctad_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (byte_s1),
		.fire   (fire),
		.res    (res)
	);

	// Output register: loaded by a character-producing word, cleared once
	// the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			char_q <= res.ch;
		end
	end

	assign char_valid = char_valid_q;
	assign ascii_char = char_q;

`ifndef SYNTH
	// A valid character word is never the null character.
	assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (ascii_char != 7'h00))
		else $error("output word carries a null character");

	// Input backpressure only comes from a full, stalled output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> (valid_s1 && char_valid && char_stall && res.emit))
		else $error("input stalled without a blocked result");

	// A decoded character lands in the output register on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.emit) |=> (char_valid && (ascii_char == $past(res.ch))))
		else $error("decoded character lost on its way to the output");
`endif

endmodule
